// File: rtl/gsf_pkg.sv
// shared types, widths and register codes of the gaussian smoothing fir
package gsf_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int OUT_W        = 24;
	localparam int WEIGHT_W     = 18;
	localparam int HALF_W       = 3;
	localparam int FRAC_W       = 16;
	localparam int NUM_WEIGHTS  = 7;
	localparam int WIDX_W       = 3;
	localparam int PROD_W       = WEIGHT_W + 1 + SAMPLE_W;
	localparam int CFG_IDX_W    = 3;
	localparam int MAX_HALF_DEF = 6;

	localparam logic [WEIGHT_W-1:0] WEIGHT_CENTER_RST = WEIGHT_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_WIDTH,
		REG_WEIGHT_CENTER,
		REG_WEIGHT_DIST1,
		REG_WEIGHT_DIST2,
		REG_WEIGHT_DIST3,
		REG_WEIGHT_DIST4,
		REG_WEIGHT_DIST5,
		REG_WEIGHT_DIST6
	} cfg_reg_e;

	typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weight_vec_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       run_end;
	} sample_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] smoothed;
		logic                    final_out;
	} result_item_t;

	typedef struct packed {
		logic step;
		logic clear;
		logic capture;
	} cell_ctl_t;

endpackage

// File: rtl/gaussian_smoothing_fir.sv
// top level of the symmetric gaussian smoothing fir
//
// samples come in on the item channel (item_valid, item_stall, item) and
// smoothed values leave on the result channel (result_valid, result_stall,
// result); a transfer happens at a clock edge with valid high and stall low.
// kernel half width and the seven q2.16 weights are written through the
// wr_en / wr_index / wr_data port; the host must write them only while
// no run is in flight, as the block does not enforce it. throughput: one
// sample per cycle while results are not stalled; a sample that ends a run
// is followed by a flush of one zero per step of half width, during which
// item_stall is high. a result passes the product register (loaded at the
// transfer edge), group-sum register and output register (final sum).
// reset clears the window of 13 tap cells to zero, sets half width to zero,
// the center weight to 1.0 and all other weights to zero.
// a stalled result holds in the output register while the product and
// group-sum stages keep filling; item_stall rises once they are full.
module gaussian_smoothing_fir import gsf_pkg::*; #(
	parameter int MAX_HALF = MAX_HALF_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  sample_item_t           item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_item_t           result,
	input  logic                   wr_en,
	input  logic [CFG_IDX_W-1:0]   wr_index,
	input  logic [WEIGHT_W-1:0]    wr_data
);

	localparam int WIN    = 2 * MAX_HALF + 1;
	localparam int SUM_W  = PROD_W + $clog2(WIN) + 1;
	localparam int FILL_W = $clog2(MAX_HALF + 2);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_HALF + 1);
	localparam logic [HALF_W-1:0] H_CAP = (MAX_HALF > 7) ? HALF_W'(7) : HALF_W'(MAX_HALF);

	// configuration registers
	logic [HALF_W-1:0] half_width_q;
	weight_vec_t       weight_q;

	// run control
	logic [FILL_W-1:0] fill_q;
	logic [HALF_W-1:0] flush_left_q;
	logic [HALF_W-1:0] flush_rem_q;

	// pipeline valid and final flags
	logic v_s1;
	logic final_s1;
	logic v_s2;
	logic final_s2;

	logic                       flushing;
	logic [HALF_W-1:0]          h_eff;
	logic [FILL_W-1:0]          fill_inc;
	logic                       rdy_s1;
	logic                       rdy_s2;
	logic                       rdy_out;
	logic                       accept;
	logic                       flush_step;
	logic                       emit;
	logic                       is_final;
	logic                       clear_win;
	logic signed [SAMPLE_W-1:0] step_sample;
	cell_ctl_t                  cell_ctl;

	logic signed [SAMPLE_W-1:0] tap   [WIN];
	logic signed [PROD_W-1:0]   prods [WIN];
	logic signed [SUM_W-1:0]    total;

	// register writes, to be issued by the host only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= '0;
			weight_q     <= {{((NUM_WEIGHTS-1)*WEIGHT_W){1'b0}}, WEIGHT_CENTER_RST};
		end else if (wr_en) begin
			unique case (cfg_reg_e'(wr_index))
				REG_HALF_WIDTH:    half_width_q <= wr_data[HALF_W-1:0];
				REG_WEIGHT_CENTER: weight_q[0]  <= wr_data;
				REG_WEIGHT_DIST1:  weight_q[1]  <= wr_data;
				REG_WEIGHT_DIST2:  weight_q[2]  <= wr_data;
				REG_WEIGHT_DIST3:  weight_q[3]  <= wr_data;
				REG_WEIGHT_DIST4:  weight_q[4]  <= wr_data;
				REG_WEIGHT_DIST5:  weight_q[5]  <= wr_data;
				REG_WEIGHT_DIST6:  weight_q[6]  <= wr_data;
				default:           half_width_q <= half_width_q;
			endcase
		end
	end

	// half width saturates at MAX_HALF
	assign h_eff = (int'(half_width_q) > MAX_HALF) ? H_CAP : half_width_q;

	// stage handshakes: a stage loads when empty or when it drains
	assign rdy_out = !result_valid || !result_stall;
	assign rdy_s2  = !v_s2 || rdy_out;
	assign rdy_s1  = !v_s1 || rdy_s2;

	assign flushing   = (flush_left_q != '0);
	assign item_stall = flushing || !rdy_s1;
	assign accept     = item_valid && !item_stall;
	assign flush_step = flushing && rdy_s1;

	assign fill_inc = (fill_q == FILL_MAX) ? fill_q : fill_q + 1'b1;

	// what a window step does: shift, emit a result, mark the run end and clear the window
	always_comb begin
		emit        = 1'b0;
		is_final    = 1'b0;
		clear_win   = 1'b0;
		step_sample = '0;
		if (accept) begin
			step_sample = item.sample;
			emit        = (int'(fill_inc) > int'(h_eff));
			is_final    = item.run_end && (h_eff == '0);
			clear_win   = is_final;
		end else if (flush_step) begin
			// zeros shifted in past the run; early ones of a short run emit nothing
			emit      = (flush_left_q <= flush_rem_q);
			is_final  = (flush_left_q == HALF_W'(1));
			clear_win = is_final;
		end
	end

	assign cell_ctl.step    = accept || flush_step;
	assign cell_ctl.clear   = clear_win;
	assign cell_ctl.capture = (accept || flush_step) && emit;

	// run fill count and flush sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			flush_left_q <= '0;
			flush_rem_q  <= '0;
		end else if (accept) begin
			if (item.run_end && (h_eff == '0)) begin
				fill_q <= '0;
			end else if (item.run_end) begin
				flush_left_q <= h_eff;
				flush_rem_q  <= (int'(fill_inc) < int'(h_eff)) ?
					HALF_W'(fill_inc) : h_eff;
			end else begin
				fill_q <= fill_inc;
			end
		end else if (flush_step) begin
			flush_left_q <= flush_left_q - 1'b1;
			if (flush_left_q == HALF_W'(1)) begin
				fill_q <= '0;
			end
		end
	end

	// row of tap cells, newest sample in cell zero
	genvar k;
	generate
		for (k = 0; k < WIN; k++) begin : g_cell
			if (k == 0) begin : g_head
				gsf_cell #(.MAX_HALF(MAX_HALF), .TAP(k)) u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (cell_ctl),
					.half    (h_eff),
					.weights (weight_q),
					.tap_in  (step_sample),
					.tap_q   (tap[k]),
					.prod_s1 (prods[k])
				);
			end else begin : g_body
				gsf_cell #(.MAX_HALF(MAX_HALF), .TAP(k)) u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (cell_ctl),
					.half    (h_eff),
					.weights (weight_q),
					.tap_in  (tap[k-1]),
					.tap_q   (tap[k]),
					.prod_s1 (prods[k])
				);
			end
		end
	endgenerate

	gsf_adder_tree #(.MAX_HALF(MAX_HALF)) u_tree (
		.clk   (clk),
		.load  (rdy_s2 && v_s1),
		.prods (prods),
		.total (total)
	);

	// valid and final flags that follow the products through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			final_s1     <= 1'b0;
			v_s2         <= 1'b0;
			final_s2     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1     <= cell_ctl.capture;
				final_s1 <= is_final;
			end
			if (rdy_s2) begin
				v_s2     <= v_s1;
				final_s2 <= final_s1;
			end
			if (rdy_out) begin
				result_valid <= v_s2;
			end
		end
	end

	// output register: floor of the sum over 2^16, low 24 bits
	always_ff @(posedge clk) begin
		if (rdy_out && v_s2) begin
			result.smoothed  <= total[FRAC_W +: OUT_W];
			result.final_out <= final_s2;
		end
	end

endmodule

// File: rtl/gsf_cell.sv
// one tap cell: window register, coefficient select and registered product
module gsf_cell import gsf_pkg::*; #(
	parameter int MAX_HALF = MAX_HALF_DEF,
	parameter int TAP      = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cell_ctl_t                  ctl,
	input  logic        [HALF_W-1:0]   half,
	input  weight_vec_t                weights,
	input  logic signed [SAMPLE_W-1:0] tap_in,
	output logic signed [SAMPLE_W-1:0] tap_q,
	output logic signed [PROD_W-1:0]   prod_s1
);

	localparam int WIN   = 2 * MAX_HALF + 1;
	localparam int IDX_W = ($clog2(WIN) + 1 > HALF_W + 1) ? $clog2(WIN) + 1 : HALF_W + 1;

	logic [IDX_W-1:0]          k_v;
	logic [IDX_W-1:0]          h_v;
	logic [IDX_W-1:0]          gap;
	logic [WEIGHT_W-1:0]       coef;
	logic signed [PROD_W-1:0]  prod_c;

	// weight by distance from the center tap, zero outside the kernel span
	always_comb begin
		k_v = IDX_W'(TAP);
		h_v = IDX_W'(half);
		gap = (k_v >= h_v) ? (k_v - h_v) : (h_v - k_v);
		if ((k_v <= (h_v << 1)) && (gap < IDX_W'(NUM_WEIGHTS))) begin
			coef = weights[gap[WIDX_W-1:0]];
		end else begin
			coef = '0;
		end
	end

	assign prod_c = $signed({1'b0, coef}) * tap_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (ctl.step) begin
			tap_q <= ctl.clear ? '0 : tap_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			prod_s1 <= prod_c;
		end
	end

endmodule

// File: rtl/gsf_adder_tree.sv
// registered adder tree over the cell products
module gsf_adder_tree import gsf_pkg::*; #(
	parameter int MAX_HALF = MAX_HALF_DEF
) (
	input  logic                     clk,
	input  logic                     load,
	input  logic signed [PROD_W-1:0] prods [2*MAX_HALF+1],
	output logic signed [PROD_W+$clog2(2*MAX_HALF+1):0] total
);

	localparam int WIN   = 2 * MAX_HALF + 1;
	localparam int SUM_W = PROD_W + $clog2(WIN) + 1;
	localparam int GRP   = 4;
	localparam int NGRP  = (WIN + GRP - 1) / GRP;

	logic signed [SUM_W-1:0] pad    [NGRP*GRP];
	logic signed [SUM_W-1:0] grp_c  [NGRP];
	logic signed [SUM_W-1:0] grp_s2 [NGRP];

	genvar j;
	generate
		for (j = 0; j < NGRP * GRP; j++) begin : g_pad
			if (j < WIN) begin : g_tap
				assign pad[j] = {{(SUM_W-PROD_W){prods[j][PROD_W-1]}}, prods[j]};
			end else begin : g_zero
				assign pad[j] = '0;
			end
		end
	endgenerate

	// first level: groups of four
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_c[g] = pad[g*GRP] + pad[g*GRP+1] + pad[g*GRP+2] + pad[g*GRP+3];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s2 <= grp_c;
		end
	end

	// second level: sum of the group totals
	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total = total + grp_s2[g];
		end
	end

endmodule
